// ===== sv/k_smallest_index_select_macros.svh =====
// Assertion helpers for the k-smallest selection checker.
`ifndef K_SMALLEST_INDEX_SELECT_MACROS_SVH
`define K_SMALLEST_INDEX_SELECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ksis_pkg.sv =====
package ksis_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;

  // Port widths are fixed by the interface.
  localparam int IN_W  = 32;
  localparam int POS_W = 6;
  localparam int CFG_W = 7;

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // Operation applied to every cell of the sorted chain in the same cycle.
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== sv/ksis_cell.sv =====
module ksis_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ksis_pkg::cell_ctrl_t ctrl_i,
  input  ksis_pkg::value_t    key_i,
  input  logic                lt_prev_i,
  input  ksis_pkg::value_t    prev_val_i,
  input  logic                prev_valid_i,
  input  ksis_pkg::value_t    next_val_i,
  input  logic                next_valid_i,
  output ksis_pkg::value_t    val_o,
  output logic                valid_o,
  output logic                lt_o
);
  import ksis_pkg::*;

  value_t val_q, val_d;
  logic   valid_q, valid_d;

  // An empty cell counts as larger than any key.
  assign lt_o = !valid_q || (key_i < val_q);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      val_d   = next_val_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert) begin
      // When the key belongs left of the neighbor, its entry moves in here.
      if (lt_prev_i) begin
        val_d   = prev_val_i;
        valid_d = prev_valid_i;
      end else if (lt_o) begin
        val_d   = key_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

// ===== sv/ksis_chain.sv =====
module ksis_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ksis_pkg::cell_ctrl_t ctrl_i,
  input  ksis_pkg::value_t     key_i,
  output ksis_pkg::value_t     head_o
);
  import ksis_pkg::*;

  value_t val   [MAX_ITEMS+1];
  logic   valid [MAX_ITEMS+1];
  logic   lt    [MAX_ITEMS+1];

  // The extra entry past the tail is an empty cell and the left edge never
  // pushes an entry in.
  assign val[MAX_ITEMS]   = '0;
  assign valid[MAX_ITEMS] = 1'b0;
  assign lt[MAX_ITEMS]    = 1'b0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    value_t prev_val;
    logic   prev_valid;
    logic   lt_prev;

    if (i == 0) begin : g_head
      assign prev_val   = '0;
      assign prev_valid = 1'b0;
      assign lt_prev    = lt[MAX_ITEMS];
    end else begin : g_body
      assign prev_val   = val[i-1];
      assign prev_valid = valid[i-1];
      assign lt_prev    = lt[i-1];
    end

    ksis_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .key_i        (key_i),
      .lt_prev_i    (lt_prev),
      .prev_val_i   (prev_val),
      .prev_valid_i (prev_valid),
      .next_val_i   (val[i+1]),
      .next_valid_i (valid[i+1]),
      .val_o        (val[i]),
      .valid_o      (valid[i]),
      .lt_o         (lt[i])
    );
  end

  assign head_o = val[0];

endmodule

// ===== sv/k_smallest_index_select.sv =====
// Channel     Signals                                   Handshake
// request     value_i, last_value_i                     start & !busy
// result      position_o, last_position_o               result_strobe_o, one cycle
// register    select_count_i                            select_count_we_i
//
// Values load one per cycle while not busy; each that finds room is inserted into
// a sorted chain of cells. A request with last_value_i and a nonzero k raises busy
// for chain shifts that move the k-th smallest value to the head, then a scan of the
// value memory, one entry per cycle through a registered read, until k positions left.
// Reset clears the chain valid bits, the fill count and sets select_count to 1.
// The receiver cannot stall; each result is shown for exactly one cycle.
module k_smallest_index_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ksis_pkg::IN_W-1:0]  value_i,
  input  logic                       last_value_i,
  input  logic                       select_count_we_i,
  input  logic [ksis_pkg::CFG_W-1:0] select_count_i,
  output logic                       result_strobe_o,
  output logic [ksis_pkg::POS_W-1:0] position_o,
  output logic                       last_position_o
);
  import ksis_pkg::*;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CFG_W-1:0] sel_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] shift_q, shift_d;
  logic [CNT_W-1:0] emit_q, emit_d;
  logic [CNT_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0] rd_pos_q, rd_pos_d;
  logic             rd_valid_q, rd_valid_d;
  value_t           rd_data_q;
  value_t           mem [MAX_ITEMS];

  value_t     key;
  value_t     head;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       room;
  logic [CNT_W-1:0] n_after;
  logic [CNT_W-1:0] k_sat;
  logic       hit;
  logic       final_hit;

  assign key     = value_t'(value_i[VALUE_BITS-1:0]);
  assign busy    = (state_q != ST_LOAD);
  assign accept  = start && !busy;
  assign room    = (count_q < CNT_W'(MAX_ITEMS));
  assign n_after = count_q + CNT_W'(room);
  assign k_sat   = (sel_q > CFG_W'(n_after)) ? n_after : CNT_W'(sel_q);

  assign hit       = (state_q == ST_SCAN) && rd_valid_q && (rd_data_q <= head);
  assign final_hit = hit && ((emit_q + CNT_W'(1)) == k_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    k_d        = k_q;
    n_d        = n_q;
    shift_d    = shift_q;
    emit_d     = emit_q;
    addr_d     = addr_q;
    rd_pos_d   = rd_pos_q;
    rd_valid_d = rd_valid_q;
    ctrl       = '0;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          ctrl.insert = room;
          count_d     = n_after;
          if (last_value_i) begin
            count_d = '0;
            if (k_sat == '0) begin
              ctrl.clear = 1'b1;
            end else begin
              state_d = ST_SHIFT;
              k_d     = k_sat;
              n_d     = n_after;
              shift_d = k_sat - CNT_W'(1);
              emit_d  = '0;
            end
          end
        end
      end
      ST_SHIFT: begin
        if (shift_q == '0) begin
          state_d    = ST_SCAN;
          addr_d     = '0;
          rd_valid_d = 1'b0;
        end else begin
          ctrl.shift = 1'b1;
          shift_d    = shift_q - CNT_W'(1);
        end
      end
      ST_SCAN: begin
        rd_valid_d = (addr_q < n_q);
        rd_pos_d   = addr_q;
        if (addr_q < n_q) begin
          addr_d = addr_q + CNT_W'(1);
        end
        if (hit) begin
          emit_d = emit_q + CNT_W'(1);
        end
        if (final_hit) begin
          state_d    = ST_LOAD;
          ctrl.clear = 1'b1;
          rd_valid_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      sel_q      <= CFG_W'(1);
      count_q    <= '0;
      k_q        <= '0;
      n_q        <= '0;
      shift_q    <= '0;
      emit_q     <= '0;
      addr_q     <= '0;
      rd_pos_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      k_q        <= k_d;
      n_q        <= n_d;
      shift_q    <= shift_d;
      emit_q     <= emit_d;
      addr_q     <= addr_d;
      rd_pos_q   <= rd_pos_d;
      rd_valid_q <= rd_valid_d;
      if (select_count_we_i) begin
        sel_q <= select_count_i;
      end
    end
  end

  // Values keep their load order here for the position scan.
  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      mem[count_q[ADDR_W-1:0]] <= key;
    end
    rd_data_q <= mem[addr_q[ADDR_W-1:0]];
  end

  ksis_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .key_i  (key),
    .head_o (head)
  );

  assign result_strobe_o = hit;
  assign position_o      = POS_W'(rd_pos_q);
  assign last_position_o = final_hit;

endmodule

// ===== sv/ksis_checker.sv =====
`include "k_smallest_index_select_macros.svh"

module ksis_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_value_i,
  input logic result_strobe_o,
  input logic last_position_o
);

  // Results only appear while a set is being selected.
  `KSIS_ASSERT_SAME(a_result_while_busy, result_strobe_o, busy, "result while idle")

  // A request that does not close the set leaves the block ready.
  `KSIS_ASSERT_NEXT(a_load_stays_ready, start && !busy && !last_value_i, !busy, "busy after load")

  // The final position of a set returns the block to loading.
  `KSIS_ASSERT_NEXT(a_done_after_last, result_strobe_o && last_position_o, !busy, "busy after final")

  // More positions follow a result that is not the final one.
  `KSIS_ASSERT_NEXT(a_more_after_mid, result_strobe_o && !last_position_o, busy, "set ended early")

endmodule

bind k_smallest_index_select ksis_checker u_ksis_checker (.*);

// ===== test/tb_k_smallest_index_select.sv =====
`timescale 1ns / 1ps

module tb_k_smallest_index_select;
  import ksis_pkg::*;

  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    value_t value;
    logic   mark;
  } request_t;

  typedef struct {
    logic [POS_W-1:0] position;
    logic             last;
  } position_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [IN_W-1:0]  value_i = '0;
  logic             last_value_i = 1'b0;
  logic             select_count_we_i = 1'b0;
  logic [CFG_W-1:0] select_count_i = '0;
  logic             result_strobe_o;
  logic [POS_W-1:0] position_o;
  logic             last_position_o;

  request_t  request_q[$];
  position_t expected_positions[$];
  position_t due;

  // Predictor state: the values of the set being loaded and the current k.
  value_t           set_values[MAX_ITEMS];
  int               set_fill = 0;
  logic [CFG_W-1:0] k_setting = 1;

  bit failed = 1'b0;
  bit req_taken = 1'b0;
  bit gap_mode = 1'b0;
  bit steady = 1'b0;
  int gap_left = 0;
  int items_sent = 0;

  k_smallest_index_select u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .value_i          (value_i),
    .last_value_i     (last_value_i),
    .select_count_we_i(select_count_we_i),
    .select_count_i   (select_count_i),
    .result_strobe_o  (result_strobe_o),
    .position_o       (position_o),
    .last_position_o  (last_position_o)
  );

  always #5 clk_i = ~clk_i;

  // Stores one value and, on the marked one, appends the positions that the
  // selection must emit for the finished set.
  function automatic void select_positions(value_t v, logic mark);
    value_t    ranked[MAX_ITEMS];
    value_t    threshold;
    position_t r;
    int        n, k, i, j, taken;
    if (set_fill < MAX_ITEMS) begin
      set_values[set_fill] = v;
      set_fill++;
    end
    if (!mark) return;
    n = set_fill;
    set_fill = 0;
    k = (int'(k_setting) > n) ? n : int'(k_setting);
    if (k == 0) return;
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && ranked[j-1] > set_values[i]) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = set_values[i];
    end
    threshold = ranked[k-1];
    taken = 0;
    for (i = 0; i < n && taken < k; i++) begin
      if (set_values[i] <= threshold) begin
        r.position = POS_W'(i);
        r.last = (taken + 1 == k);
        expected_positions.push_back(r);
        taken++;
      end
    end
  endfunction

  // Request driver: a request stays on the ports until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !req_taken) begin
        // Hold the current request.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (request_q.size() > 0) begin
        if (gap_mode && !steady && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 3);
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          value_i <= request_q[0].value;
          last_value_i <= request_q[0].mark;
        end
      end else begin
        start <= 1'b0;
      end
      req_taken = 1'b0;
    end
  end

  // Monitor: checks results first, then predicts from the request taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected result: position %0d, last_position %0b",
                 position_o, last_position_o);
          failed = 1'b1;
        end else begin
          due = expected_positions.pop_front();
          if (position_o !== due.position) begin
            $error("position: expected %0d, actual %0d", due.position, position_o);
            failed = 1'b1;
          end
          if (last_position_o !== due.last) begin
            $error("last_position: expected %0b, actual %0b", due.last, last_position_o);
            failed = 1'b1;
          end
        end
      end
      if (select_count_we_i) k_setting = select_count_i;
      if (start && !busy) begin
        select_positions(value_t'(value_i), last_value_i);
        void'(request_q.pop_front());
        req_taken = 1'b1;
      end
    end
  end

  function automatic value_t pick_value(int style);
    case (style)
      0: return value_t'($urandom);
      1: return value_t'(int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic push_request(value_t v, logic mark);
    request_t q;
    q.value = v;
    q.mark = mark;
    request_q.push_back(q);
    items_sent++;
  endtask

  task automatic load_set(int n, int style);
    for (int i = 0; i < n; i++) push_request(pick_value(style), i == n - 1);
  endtask

  // Waits until every request is taken and every result is in, then lets the
  // block finish any selection that produces no results.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || start || expected_positions.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] k);
    wait_idle();
    @(negedge clk_i);
    select_count_we_i <= 1'b1;
    select_count_i <= k;
    @(negedge clk_i);
    select_count_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_W-1:0] k;
    int sets, size;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset count of one: the minimum sits among the extremes.
    push_request(32'sh7FFF_FFFF, 1'b0);
    push_request(32'sh8000_0000, 1'b0);
    push_request(32'sh0000_0000, 1'b0);
    push_request(-32'sd1, 1'b1);

    // Ties at the threshold go to the earliest positions.
    write_count(3);
    for (int i = 0; i < 5; i++) push_request(32'sd5, i == 4);
    push_request(pick_value(0), 1'b1);

    // A count of zero selects nothing.
    write_count(0);
    load_set(3, 0);

    // Counts above the set size emit every position.
    write_count(127);
    load_set(4, 1);
    write_count(64);
    load_set(5, 2);

    // Full store: values past the last entry are dropped, but the mark still closes the set.
    gap_mode = 1'b1;
    write_count(64);
    load_set(66, 0);
    load_set(64, 1);

    while (items_sent < 230) begin
      case ($urandom_range(0, 5))
        0: k = 1;
        1: k = 64;
        2: k = 127;
        3: k = 0;
        4: k = CFG_W'($urandom_range(1, 64));
        default: k = CFG_W'($urandom_range(0, 127));
      endcase
      steady = (items_sent >= 190);
      write_count(k);
      gap_mode = ($urandom_range(0, 2) != 0);
      sets = $urandom_range(1, 3);
      for (int s = 0; s < sets && items_sent < 230; s++) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        // Keep the total close to the intended item count.
        if (items_sent + size > 240) size = 240 - items_sent;
        load_set(size, $urandom_range(0, 2));
      end
    end

    wait_idle();
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ksis_pkg.sv
sv/ksis_cell.sv
sv/ksis_chain.sv
sv/k_smallest_index_select.sv
sv/ksis_checker.sv
test/tb_k_smallest_index_select.sv
